@@ sv/fct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

  localparam int OP_W        = 2;
  localparam int PLANE_IDX_W = 3;
  localparam int COEFF_IDX_W = 2;
  localparam int NUM_COEFFS  = 4;
  localparam int NUM_AXES    = 3;

  localparam int COEFF_D = 3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_POINT  = 2'd1,
    OP_SPHERE = 2'd2,
    OP_BOX    = 2'd3
  } op_t;

  typedef struct packed {
    logic valid;
    logic last;
  } eval_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic culled;
  } eval_res_t;

endpackage

`default_nettype wire

@@ sv/fct_plane_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fct_plane_eval
  import fct_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire eval_ctl_t                             ctl,
  input  wire op_t                                   op,
  input  wire logic [NUM_COEFFS*COORD_WIDTH-1:0]     row,
  input  wire logic signed [COORD_WIDTH-1:0]         pos_x,
  input  wire logic signed [COORD_WIDTH-1:0]         pos_y,
  input  wire logic signed [COORD_WIDTH-1:0]         pos_z,
  input  wire logic [COORD_WIDTH-2:0]                sphere_radius,
  input  wire logic [COORD_WIDTH-2:0]                half_x,
  input  wire logic [COORD_WIDTH-2:0]                half_y,
  input  wire logic [COORD_WIDTH-2:0]                half_z,
  output eval_res_t                                  res
);

  localparam int EXT_W  = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * COORD_WIDTH + 1;
  localparam int SUM_W  = 2 * COORD_WIDTH + 3;

  logic signed [COORD_WIDTH-1:0] coef   [NUM_COEFFS];
  logic signed [COORD_WIDTH-1:0] pos    [NUM_AXES];
  logic        [COORD_WIDTH-2:0] half   [NUM_AXES];
  logic signed [EXT_W-1:0]       opnd   [NUM_AXES];
  logic signed [PROD_W-1:0]      prod_next [NUM_AXES];
  logic signed [PROD_W-1:0]      prod   [NUM_AXES];
  logic        [COORD_WIDTH-2:0] rad_sel;
  logic signed [SUM_W-1:0]       dterm_next;
  logic signed [SUM_W-1:0]       dterm;
  logic signed [SUM_W-1:0]       sum;
  eval_ctl_t                     ctl_a;

  // For a box, the corner farthest along the plane normal gives the largest distance.
  always_comb begin
    for (int k = 0; k < NUM_COEFFS; k++) begin
      coef[k] = row[k*COORD_WIDTH +: COORD_WIDTH];
    end
    pos[0]  = pos_x;
    pos[1]  = pos_y;
    pos[2]  = pos_z;
    half[0] = (op == OP_BOX) ? half_x : '0;
    half[1] = (op == OP_BOX) ? half_y : '0;
    half[2] = (op == OP_BOX) ? half_z : '0;
    for (int k = 0; k < NUM_AXES; k++) begin
      if (coef[k][COORD_WIDTH-1]) begin
        opnd[k] = EXT_W'(pos[k]) - signed'({2'b00, half[k]});
      end else begin
        opnd[k] = EXT_W'(pos[k]) + signed'({2'b00, half[k]});
      end
      prod_next[k] = PROD_W'(coef[k]) * PROD_W'(opnd[k]);
    end
    rad_sel    = (op == OP_SPHERE) ? sphere_radius : '0;
    dterm_next = (SUM_W'(coef[COEFF_D]) <<< FRAC_BITS)
               + (SUM_W'(signed'({1'b0, rad_sel})) <<< FRAC_BITS);
  end

  always_comb begin
    sum = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + dterm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
      res   <= '0;
    end else begin
      ctl_a      <= ctl;
      res.valid  <= ctl_a.valid;
      res.last   <= ctl_a.last;
      res.culled <= sum[SUM_W-1] || (sum == '0);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_AXES; k++) begin
      prod[k] <= prod_next[k];
    end
    dterm <= dterm_next;
  end

endmodule

`default_nettype wire

@@ sv/frustum_culling_tester.sv @@
// Six-plane view frustum culling tester.
// Requests arrive on a valid/ready channel. A write request loads one plane
// coefficient into the plane memory and completes in the cycle it is taken.
// A test request checks a point, a sphere or a box against every plane and
// returns one inside flag on the result channel.
// A test reads one plane row per cycle from the coefficient memory into a
// row register; the three coefficient multiplies are registered, and the
// sum and sign check is registered in the result register. No new request
// is taken until the test result has been written to the output register,
// so writes run at one per cycle only while no test is in progress.
// The result sits in an output register: a write request is still taken
// while it waits. If a test finishes while the previous result has not been
// taken, the new flag is held until the receiver takes the older one.
// Reset clears the control state and marks every coefficient as zero at
// once through per-coefficient valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module frustum_culling_tester
  import fct_pkg::*;
#(
  parameter int NUM_PLANES  = 6,
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire logic [OP_W-1:0]               operation,
  input  wire logic [PLANE_IDX_W-1:0]        plane_index,
  input  wire logic [COEFF_IDX_W-1:0]        coeff_index,
  input  wire logic signed [COORD_WIDTH-1:0] coeff_value,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y,
  input  wire logic signed [COORD_WIDTH-1:0] pos_z,
  input  wire logic [COORD_WIDTH-2:0]        sphere_radius,
  input  wire logic [COORD_WIDTH-2:0]        half_x,
  input  wire logic [COORD_WIDTH-2:0]        half_y,
  input  wire logic [COORD_WIDTH-2:0]        half_z,
  output logic                               rsp_valid,
  input  wire logic                          rsp_ready,
  output logic                               inside_res
);

  localparam int PW    = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int ROW_W = NUM_COEFFS * COORD_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_HOLD
  } state_t;

  state_t                        state;
  logic [PW-1:0]                 cnt;
  logic                          last_plane;
  logic                          culled_acc;
  logic                          hold_inside;
  logic                          test_inside;
  logic                          wr_en;
  logic [PW-1:0]                 wr_addr;
  op_t                           req_op;

  logic [ROW_W-1:0]              plane_mem [NUM_PLANES];
  logic [NUM_COEFFS-1:0]         coeff_vld [NUM_PLANES];
  logic [ROW_W-1:0]              row_q;
  logic [NUM_COEFFS-1:0]         vld_q;
  logic [ROW_W-1:0]              row_masked;
  eval_ctl_t                     rd_ctl;
  eval_res_t                     ev_res;

  op_t                           op_q;
  logic signed [COORD_WIDTH-1:0] x_q;
  logic signed [COORD_WIDTH-1:0] y_q;
  logic signed [COORD_WIDTH-1:0] z_q;
  logic [COORD_WIDTH-2:0]        rad_q;
  logic [COORD_WIDTH-2:0]        hx_q;
  logic [COORD_WIDTH-2:0]        hy_q;
  logic [COORD_WIDTH-2:0]        hz_q;

  assign req_op      = op_t'(operation);
  assign req_ready   = (state == S_IDLE);
  assign last_plane  = (cnt == PW'(NUM_PLANES - 1));
  assign wr_addr     = PW'(plane_index);
  assign wr_en       = req_valid && req_ready && (req_op == OP_WRITE)
                       && (32'(plane_index) < 32'(NUM_PLANES));
  assign test_inside = !(culled_acc || ev_res.culled);

  always_comb begin
    for (int k = 0; k < NUM_COEFFS; k++) begin
      row_masked[k*COORD_WIDTH +: COORD_WIDTH] =
        row_q[k*COORD_WIDTH +: COORD_WIDTH] & {COORD_WIDTH{vld_q[k]}};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < NUM_COEFFS; k++) begin
        if (coeff_index == COEFF_IDX_W'(k)) begin
          plane_mem[wr_addr][k*COORD_WIDTH +: COORD_WIDTH] <= coeff_value;
        end
      end
    end
    if (state == S_ISSUE) begin
      row_q <= plane_mem[cnt];
      vld_q <= coeff_vld[cnt];
    end
  end

  // A coefficient never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        coeff_vld[p] <= '0;
      end
    end else if (wr_en) begin
      for (int k = 0; k < NUM_COEFFS; k++) begin
        if (coeff_index == COEFF_IDX_W'(k)) begin
          coeff_vld[wr_addr][k] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready && (req_op != OP_WRITE)) begin
      op_q  <= req_op;
      x_q   <= pos_x;
      y_q   <= pos_y;
      z_q   <= pos_z;
      rad_q <= sphere_radius;
      hx_q  <= half_x;
      hy_q  <= half_y;
      hz_q  <= half_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      rd_ctl      <= '0;
      culled_acc  <= 1'b0;
      hold_inside <= 1'b0;
      rsp_valid   <= 1'b0;
      inside_res  <= 1'b0;
    end else begin
      rd_ctl <= '0;
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (ev_res.valid && !ev_res.last) begin
        culled_acc <= culled_acc || ev_res.culled;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid && (req_op != OP_WRITE)) begin
            state      <= S_ISSUE;
            cnt        <= '0;
            culled_acc <= 1'b0;
          end
        end
        S_ISSUE: begin
          rd_ctl.valid <= 1'b1;
          rd_ctl.last  <= last_plane;
          if (last_plane) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + PW'(1);
          end
        end
        S_DRAIN: begin
          if (ev_res.valid && ev_res.last) begin
            if (!rsp_valid || rsp_ready) begin
              rsp_valid  <= 1'b1;
              inside_res <= test_inside;
              state      <= S_IDLE;
            end else begin
              hold_inside <= test_inside;
              state       <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (rsp_ready) begin
            rsp_valid  <= 1'b1;
            inside_res <= hold_inside;
            state      <= S_IDLE;
          end
        end
      endcase
    end
  end

  fct_plane_eval #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_eval (
    .clk           (clk),
    .rst           (rst),
    .ctl           (rd_ctl),
    .op            (op_q),
    .row           (row_masked),
    .pos_x         (x_q),
    .pos_y         (y_q),
    .pos_z         (z_q),
    .sphere_radius (rad_q),
    .half_x        (hx_q),
    .half_y        (hy_q),
    .half_z        (hz_q),
    .res           (ev_res)
  );

`ifndef ASSERT_OFF
  a_no_eval_when_idle: assert property (@(posedge clk) disable iff (rst)
    ev_res.valid |-> (state == S_ISSUE || state == S_DRAIN))
    else $error("plane result arrived outside a test");

  a_no_read_when_ready: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !rd_ctl.valid)
    else $error("plane read in flight while taking requests");

  a_hold_has_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> rsp_valid)
    else $error("held result without a pending output");

  a_last_ends_issue: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE && last_plane) |=> (state == S_DRAIN && rd_ctl.last))
    else $error("last plane read did not end the issue phase");
`endif

endmodule

`default_nettype wire
